### rtl/core/assert_macros.svh
// assertion macros for the sorted table search rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define STUB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold outside reset
`define STUB_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `STUB_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

### rtl/core/stub_pkg.sv
// types and constants of the sorted table upper bound search
`timescale 1ns / 1ps

package stub_pkg;

  localparam int POS_W   = 9;
  localparam int INDEX_W = 8;
  localparam int WORD_W  = 32;
  localparam int OUT_TDATA_W = 16;
  localparam int IN_TDATA_W  = 72;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef struct packed {
    logic write;     // store one table entry
    logic load;      // start a search window
    logic step;      // one halving probe
    logic out_load;  // capture the result into the output register
  } cmd_t;

  typedef struct packed {
    logic empty;     // search window has closed
  } status_t;

endpackage

### rtl/core/sorted_table_upper_bound_top.sv
// top level of the sorted table upper bound search
//
// input stream: in_tuser selects the operation (0 stores in_tdata entry_value at
// entry_index, 1 searches for in_tdata search_key). a store gives no output
// transfer. a search returns on the output stream the first table index whose
// entry is greater than the key, or the entry count saturated at the table depth.
// cfg_we with cfg_wdata sets the number of valid entries; write it only while
// no search is in flight.
// a search halves the window [0, entry count) with one probe per halving step,
// each probe reading the registered table, until the window closes; the result
// then goes into the output register.
// one search is in flight at a time; in_tready stays low until its result is
// in the output register.
// a stalled receiver holds the result in the output register; stores are still
// taken, and one more search is taken and run, and its result waits in the
// search window until the output register frees up.
// reset clears the entry count to zero and drops any pending result; table
// contents are not cleared and must be written before they are searched.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module sorted_table_upper_bound_top #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,   // entry_count
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,    // entry_index[7:0], entry_value[39:8], search_key[71:40]
  input  logic        in_tuser,    // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata    // position[8:0], zero fill [15:9]
);

  stub_pkg::cmd_t                cmd;
  stub_pkg::status_t             status;
  logic [stub_pkg::POS_W-1:0]    position;

  stub_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_func    (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  stub_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_entry_index (in_tdata[7:0]),
    .in_entry_value (in_tdata[39:8]),
    .in_search_key  (in_tdata[71:40]),
    .status         (status),
    .position       (position)
  );

  assign out_tdata = {(stub_pkg::OUT_TDATA_W - stub_pkg::POS_W)'(0), position};

  `STUB_ASSERT(a_busy_after_load, clk, rst_n, cmd.load |=> !in_tready, "input taken during search")
  `STUB_ASSERT(a_result_on_empty, clk, rst_n, cmd.out_load |-> status.empty, "result before window closed")
  `STUB_ASSERT_NEVER(a_step_when_idle, clk, rst_n, cmd.step && (in_tready || status.empty), "probe outside search")

endmodule

### rtl/core/stub_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module stub_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/stub_ctrl.sv
// controller state machine for the table search
`timescale 1ns / 1ps

module stub_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_func,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  stub_pkg::status_t status,
  output stub_pkg::cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PROBE = 2'd1;
  localparam logic [1:0] ST_HOLD  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign accept     = in_tvalid & in_tready;
  assign out_free   = !out_valid_r | out_tready;

  always_comb begin
    cmd.write    = accept & (in_func == stub_pkg::FUNC_WRITE);
    cmd.load     = accept & (in_func == stub_pkg::FUNC_SEARCH);
    cmd.step     = (state_r == ST_PROBE) & !status.empty;
    cmd.out_load = ((state_r == ST_PROBE) | (state_r == ST_HOLD)) & status.empty & out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.load) begin
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (status.empty) begin
          state_nxt = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/core/stub_dp.sv
// search datapath: table memory, window registers, key and result register
`timescale 1ns / 1ps

module stub_dp #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  stub_pkg::cmd_t                 cmd,
  input  logic                           cfg_we,
  input  logic [stub_pkg::POS_W-1:0]     cfg_wdata,
  input  logic [stub_pkg::INDEX_W-1:0]   in_entry_index,
  input  logic [stub_pkg::WORD_W-1:0]    in_entry_value,
  input  logic [stub_pkg::WORD_W-1:0]    in_search_key,
  output stub_pkg::status_t              status,
  output logic [stub_pkg::POS_W-1:0]     position
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [stub_pkg::POS_W-1:0]  count_r;
  logic [stub_pkg::POS_W-1:0]  eff_count;
  logic [stub_pkg::POS_W-1:0]  low_r, low_nxt;
  logic [stub_pkg::POS_W-1:0]  high_r, high_nxt;
  logic [stub_pkg::POS_W-1:0]  mid_r, mid_nxt;
  logic [stub_pkg::POS_W-1:0]  pos_r;
  logic [stub_pkg::WORD_W-1:0] key_r;
  logic [stub_pkg::WORD_W-1:0] rdata;
  logic                        ram_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_we) begin
      count_r <= cfg_wdata;
    end
  end

  // a count beyond the table covers the whole table
  assign eff_count = (32'(count_r) > TABLE_DEPTH) ? stub_pkg::POS_W'(TABLE_DEPTH) : count_r;

  // writes past the end of the table are dropped
  assign ram_we = cmd.write & (32'(in_entry_index) < TABLE_DEPTH);

  always_comb begin
    low_nxt  = low_r;
    high_nxt = high_r;
    if (cmd.load) begin
      low_nxt  = '0;
      high_nxt = eff_count;
    end else if (cmd.step) begin
      if (rdata <= key_r) begin
        low_nxt = mid_r + stub_pkg::POS_W'(1);
      end else begin
        high_nxt = mid_r;
      end
    end
  end

  // next probe address goes straight to the ram so the probed entry arrives together with mid_r
  assign mid_nxt = low_nxt + ((high_nxt - low_nxt) >> 1);

  stub_ram #(
    .WIDTH (stub_pkg::WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_entry_index)),
    .wdata (in_entry_value),
    .raddr (AW'(mid_nxt)),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    low_r  <= low_nxt;
    high_r <= high_nxt;
    mid_r  <= mid_nxt;
    if (cmd.load) begin
      key_r <= in_search_key;
    end
    if (cmd.out_load) begin
      pos_r <= low_r;
    end
  end

  assign status.empty = (low_r >= high_r);
  assign position     = pos_r;

endmodule

### dv/sorted_table_upper_bound_checker.sv
// checker that mirrors the sorted table and compares every search result
`timescale 1ns / 1ps

module sorted_table_upper_bound_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] in_tdata,    // entry_index[7:0], entry_value[39:8], search_key[71:40]
  input  logic        in_tuser,    // func
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,   // position[8:0], zero fill [15:9]
  output int          mismatch_count,
  output int          positions_pending,
  output int          positions_checked
);

  localparam int DEPTH = 256;

  logic [stub_pkg::WORD_W-1:0] entry_words [DEPTH];
  logic [8:0]                  entry_count;
  logic [stub_pkg::POS_W-1:0]  expected_positions [$];

  // halving probe over [0, count), count saturated at the table depth
  function automatic logic [stub_pkg::POS_W-1:0] upper_bound_of(
      input logic [stub_pkg::WORD_W-1:0] key);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = (int'(entry_count) > DEPTH) ? DEPTH : int'(entry_count);
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (entry_words[stub_pkg::INDEX_W'(mid)] <= key) lo = mid + 1;
      else hi = mid;
    end
    return stub_pkg::POS_W'(lo);
  endfunction

  always @(posedge clk) begin
    logic [stub_pkg::POS_W-1:0] want;
    logic [stub_pkg::POS_W-1:0] got;
    if (!rst_n) begin
      expected_positions.delete();
      entry_count       <= '0;
      mismatch_count    <= 0;
      positions_pending <= 0;
      positions_checked <= 0;
    end else begin
      if (cfg_we) entry_count <= cfg_wdata;
      // retire results before queuing new ones so a stray result is never masked
      if (out_tvalid && out_tready) begin
        got = out_tdata[stub_pkg::POS_W-1:0];
        if (expected_positions.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none, actual position %0d",
                   $time, got);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_positions.pop_front();
          positions_checked <= positions_checked + 1;
          if (got !== want) begin
            $display("%0t: position mismatch, expected %0d, actual %0d", $time, want, got);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == stub_pkg::FUNC_WRITE) begin
          entry_words[in_tdata[stub_pkg::INDEX_W-1:0]] <=
            in_tdata[stub_pkg::INDEX_W +: stub_pkg::WORD_W];
        end else begin
          expected_positions.push_back(
            upper_bound_of(in_tdata[stub_pkg::INDEX_W+stub_pkg::WORD_W +: stub_pkg::WORD_W]));
        end
      end
      positions_pending <= expected_positions.size();
    end
  end

endmodule

### dv/sorted_table_upper_bound_top_tb.sv
// testbench top: stimulus, idle patterns and verdict for the sorted table search
`timescale 1ns / 1ps

module sorted_table_upper_bound_top_tb;

  localparam int TARGET_ITEMS  = 1900;
  localparam int SETTLE_CYCLES = 16;
  localparam int DEPTH         = 256;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [8:0]  cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        in_tuser = stub_pkg::FUNC_WRITE;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  int mismatch_count;
  int positions_pending;
  int positions_checked;

  int tx_idle_pct = 21;
  int rx_idle_pct = 64;
  int items_sent = 0;
  int writes_sent = 0;
  int count_settings = 0;
  int live_count = 0;
  // what the table is meant to hold, used only to aim search keys
  logic [stub_pkg::WORD_W-1:0] shadow_words [DEPTH];

  sorted_table_upper_bound_top #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  sorted_table_upper_bound_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tuser         (in_tuser),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .mismatch_count   (mismatch_count),
    .positions_pending(positions_pending),
    .positions_checked(positions_checked)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= rst_n && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // called at a rising edge; returns at the edge where the transfer happened
  task automatic send_item(input logic func, input logic [stub_pkg::INDEX_W-1:0] idx,
                           input logic [stub_pkg::WORD_W-1:0] value,
                           input logic [stub_pkg::WORD_W-1:0] key);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {key, value, idx};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    items_sent++;
    // receiver-heavy idling, then sender-heavy, then none
    case (items_sent * 3 / TARGET_ITEMS)
      0: begin
        tx_idle_pct = 21;
        rx_idle_pct = 64;
      end
      1: begin
        tx_idle_pct = 64;
        rx_idle_pct = 21;
      end
      default: begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
    endcase
  endtask

  task automatic store_entry(input int idx, input logic [stub_pkg::WORD_W-1:0] value);
    send_item(stub_pkg::FUNC_WRITE, stub_pkg::INDEX_W'(idx), value, $urandom());
    shadow_words[stub_pkg::INDEX_W'(idx)] = value;
    writes_sent++;
  endtask

  task automatic search_for(input logic [stub_pkg::WORD_W-1:0] key);
    send_item(stub_pkg::FUNC_SEARCH, stub_pkg::INDEX_W'($urandom_range(0, 255)), $urandom(),
              key);
  endtask

  task automatic set_entry_count(input logic [8:0] n);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (positions_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
    live_count = (int'(n) > DEPTH) ? DEPTH : int'(n);
    count_settings++;
  endtask

  // ascending values with some repeats, spread over the whole word range
  task automatic load_sorted(input int n);
    logic [stub_pkg::WORD_W-1:0] step_max;
    logic [stub_pkg::WORD_W-1:0] value;
    step_max = 32'hFFFF_FFFF / (n + 1);
    value = $urandom_range(0, step_max);
    for (int i = 0; i < n; i++) begin
      if (i != 0 && $urandom_range(0, 3) != 0) value += $urandom_range(1, step_max);
      store_entry(i, value);
    end
  endtask

  function automatic logic [stub_pkg::WORD_W-1:0] pick_key();
    logic [stub_pkg::WORD_W-1:0] hit;
    if (live_count == 0) return $urandom();
    hit = shadow_words[stub_pkg::INDEX_W'($urandom_range(0, live_count - 1))];
    case ($urandom_range(0, 5))
      0: return hit;
      1: return hit - 1;
      2: return hit + 1;
      3: return '0;
      4: return '1;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [8:0] next_count;
    int phase_no;
    int phase_items;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table after reset
    search_for(32'h0000_0000);
    search_for(32'hFFFF_FFFF);
    // small table with a duplicate pair and the largest word on top
    store_entry(0, 32'h0000_0000);
    store_entry(1, 32'h0000_0005);
    store_entry(2, 32'h0000_0005);
    store_entry(3, 32'hFFFF_FFFF);
    store_entry(255, 32'hA5A5_A5A5);
    set_entry_count(9'd4);
    search_for(32'h0000_0000);
    search_for(32'h0000_0004);
    search_for(32'h0000_0005);
    search_for(32'h0000_0006);
    search_for(32'hFFFF_FFFE);
    search_for(32'hFFFF_FFFF);
    // break the ordering: result follows the probe sequence
    store_entry(1, 32'hFFFF_FFF0);
    search_for(32'h0000_0005);
    search_for(32'hFFFF_FFF0);

    phase_no = 0;
    while (items_sent < TARGET_ITEMS) begin
      case (phase_no)
        0: next_count = 9'd256;
        1: next_count = 9'd0;
        2: next_count = 9'd1;
        3: next_count = 9'd511;
        4: next_count = 9'd255;
        5: next_count = 9'd2;
        default: begin
          if ($urandom_range(0, 7) == 0) next_count = 9'($urandom_range(33, 511));
          else next_count = 9'($urandom_range(1, 32));
        end
      endcase
      load_sorted((int'(next_count) > DEPTH) ? DEPTH : int'(next_count));
      set_entry_count(next_count);
      phase_items = $urandom_range(20, 60);
      for (int i = 0; i < phase_items; i++) begin
        if ($urandom_range(0, 99) < 10) store_entry($urandom_range(0, 255), $urandom());
        else search_for(pick_key());
      end
      phase_no++;
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (positions_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d checked searches and %0d table writes", positions_checked,
             writes_sent);
    $display("over %0d entry count settings from empty to a saturating 511", count_settings);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
